// File: hw/rtl/ple_pkg.sv
`default_nettype none

package ple_pkg;

	localparam int MODE_W = 3;
	localparam int POS_W  = 5;
	localparam int VAL_W  = 32;
	localparam int FPOS_W = 4;
	localparam int LEN_W  = 5;
	localparam int ST_W   = 2;

	localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_GET    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SET    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FIND   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0]       mode;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		logic                    found;
		logic [FPOS_W-1:0]       found_position;
		logic [LEN_W-1:0]        list_length;
		logic [ST_W-1:0]         status;
	} rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/ple_ram.sv
`default_nettype none

module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/positional_list_engine.sv
`default_nettype none

// Ordered list of up to DEPTH signed 32-bit values held in one simple dual-port RAM
// (one write and one registered read per cycle), with the entry count in a register.
// Requests are handled one at a time; how long each takes is set by how many
// entries must pass through the RAM ports. Clear, set, append, find on an empty
// list and every error write at most one entry; get reads one; insert at p moves
// each later entry up by one read and one write per cycle, then writes the value;
// remove at p reads that entry, then moves each later one down; find reads from
// position 0 until the value is found or the list ends. A new request is taken
// while the previous result still waits to be transferred; a finished result only
// waits further if the output is stalled. Positions never written are never read.
module positional_list_engine #(
	parameter int DEPTH = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire ple_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output ple_pkg::rsp_t      rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int PW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_SHDN = 3'd2;
	localparam logic [2:0] S_SHUP = 3'd3;
	localparam logic [2:0] S_PUT  = 3'd4;
	localparam logic [2:0] S_SCAN = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]                       state_q, state_d;
	logic [CW-1:0]                    count_q, count_d;
	logic [AW-1:0]                    idx_q, idx_d;
	logic [ple_pkg::MODE_W-1:0]       mode_q, mode_d;
	logic [AW-1:0]                    pos_q, pos_d;
	logic signed [ple_pkg::VAL_W-1:0] val_q, val_d;
	logic signed [ple_pkg::VAL_W-1:0] rd_q, rd_d;
	logic                             fnd_q, fnd_d;
	logic [AW-1:0]                    fpos_q, fpos_d;
	logic [ple_pkg::ST_W-1:0]         st_q, st_d;
	logic                             rsp_valid_q;
	ple_pkg::rsp_t                    rsp_q;

	logic                     ram_we, ram_re;
	logic [AW-1:0]            ram_waddr, ram_raddr;
	logic [ple_pkg::VAL_W-1:0] ram_wdata, ram_rdata;

	logic          req_fire, slot_free, rsp_load;
	logic [PW-1:0] pos_w, cnt_w;
	logic [CW-1:0] next_idx;

	ple_ram #(
		.WIDTH(ple_pkg::VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req_stall = (state_q != S_IDLE);
	assign req_fire  = req_valid && (state_q == S_IDLE);
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign rsp_load  = (state_q == S_DONE) && slot_free;
	assign pos_w     = PW'(req.position);
	assign cnt_w     = PW'(count_q);
	assign next_idx  = CW'(idx_q) + CW'(1);

	// The sequencer reads ahead of its writes: shifting down writes below the read
	// address and shifting up writes above it, so no entry is read in the cycle it
	// is written, and a new request starts reading only after the last write landed.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		mode_d    = mode_q;
		pos_d     = pos_q;
		val_d     = val_q;
		rd_d      = rd_q;
		fnd_d     = fnd_q;
		fpos_d    = fpos_q;
		st_d      = st_q;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = val_q;
		ram_re    = 1'b0;
		ram_raddr = '0;

		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					mode_d  = req.mode;
					pos_d   = AW'(req.position);
					val_d   = req.item_value;
					rd_d    = '0;
					fnd_d   = 1'b0;
					fpos_d  = '0;
					st_d    = ple_pkg::ST_OK;
					state_d = S_DONE;
					case (req.mode)
						ple_pkg::MODE_INSERT: begin
							if (count_q == CW'(DEPTH)) begin
								st_d = ple_pkg::ST_FULL;
							end else if (pos_w > cnt_w) begin
								st_d = ple_pkg::ST_RANGE;
							end else if (pos_w == cnt_w) begin
								ram_we    = 1'b1;
								ram_waddr = AW'(req.position);
								ram_wdata = req.item_value;
								count_d   = count_q + CW'(1);
							end else begin
								ram_re    = 1'b1;
								ram_raddr = AW'(count_q - CW'(1));
								idx_d     = AW'(count_q - CW'(1));
								state_d   = S_SHUP;
							end
						end
						ple_pkg::MODE_REMOVE, ple_pkg::MODE_GET, ple_pkg::MODE_SET: begin
							if (count_q == '0) begin
								st_d = ple_pkg::ST_EMPTY;
							end else if (pos_w >= cnt_w) begin
								st_d = ple_pkg::ST_RANGE;
							end else if (req.mode == ple_pkg::MODE_SET) begin
								ram_we    = 1'b1;
								ram_waddr = AW'(req.position);
								ram_wdata = req.item_value;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = AW'(req.position);
								state_d   = S_READ;
							end
						end
						ple_pkg::MODE_FIND: begin
							if (count_q != '0) begin
								ram_re    = 1'b1;
								ram_raddr = '0;
								idx_d     = '0;
								state_d   = S_SCAN;
							end
						end
						ple_pkg::MODE_CLEAR: begin
							count_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
				rd_d = ram_rdata;
				if (mode_q == ple_pkg::MODE_REMOVE) begin
					if (CW'(pos_q) + CW'(1) < count_q) begin
						ram_re    = 1'b1;
						ram_raddr = AW'(CW'(pos_q) + CW'(1));
						idx_d     = AW'(CW'(pos_q) + CW'(1));
						state_d   = S_SHDN;
					end else begin
						count_d = count_q - CW'(1);
						state_d = S_DONE;
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_SHDN: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q - AW'(1);
				ram_wdata = ram_rdata;
				if (next_idx < count_q) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(next_idx);
					idx_d     = AW'(next_idx);
				end else begin
					count_d = count_q - CW'(1);
					state_d = S_DONE;
				end
			end
			S_SHUP: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q + AW'(1);
				ram_wdata = ram_rdata;
				if (idx_q > pos_q) begin
					ram_re    = 1'b1;
					ram_raddr = idx_q - AW'(1);
					idx_d     = idx_q - AW'(1);
				end else begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = val_q;
				count_d   = count_q + CW'(1);
				state_d   = S_DONE;
			end
			S_SCAN: begin
				if (ram_rdata == val_q) begin
					fnd_d   = 1'b1;
					fpos_d  = idx_q;
					state_d = S_DONE;
				end else if (next_idx < count_q) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(next_idx);
					idx_d     = AW'(next_idx);
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		mode_q <= mode_d;
		pos_q  <= pos_d;
		val_q  <= val_d;
		rd_q   <= rd_d;
		fnd_q  <= fnd_d;
		fpos_q <= fpos_d;
		st_q   <= st_d;
		if (rsp_load) begin
			rsp_q.read_value     <= rd_q;
			rsp_q.found          <= fnd_q;
			rsp_q.found_position <= ple_pkg::FPOS_W'(fpos_q);
			rsp_q.list_length    <= ple_pkg::LEN_W'(count_q);
			rsp_q.status         <= st_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds list depth");

	a_count_moves_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> state_q == S_DONE)
		else $error("entry count changed outside the end of a request");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result presented without a finished request");

	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_waddr != ram_raddr)
		else $error("RAM read and write hit the same entry in one cycle");

	a_read_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_SHDN) |-> CW'(idx_q) < count_q)
		else $error("sequencer read an entry beyond the list");
`endif

endmodule

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH    = 16;
	localparam int RANDOM_ITEMS  = 1480;
	localparam int QUIET_ITEMS   = 150;
	localparam int LONG_HOLD_AT  = 400;
	localparam int LONG_HOLD_LEN = 150;
	localparam int DRAIN_AT      = 800;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 400000;

	// Modes 6 and 7 have no meaning; the block must leave the list alone.
	localparam logic [ple_pkg::MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
	localparam logic [ple_pkg::MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

	localparam logic signed [ple_pkg::VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [ple_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

	typedef enum int {EP_GROW, EP_SHRINK, EP_MIXED, EP_PROBE} episode_e;

	typedef struct {
		ple_pkg::req_t r;
		bit            typed;
		ple_pkg::rsp_t want;
	} stim_row_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	ple_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	ple_pkg::rsp_t rsp;

	// Shadow copy of the list contents and length.
	logic signed [ple_pkg::VAL_W-1:0] list_mem [LIST_DEPTH];
	int unsigned                      list_count = 0;

	ple_pkg::rsp_t pending_results [$];
	stim_row_t     stim_rows [$];

	int unsigned cycle_count   = 0;
	int unsigned errors        = 0;
	int unsigned requests_sent = 0;
	int unsigned results_seen  = 0;
	int unsigned full_refusals = 0;
	int unsigned empty_refusals = 0;
	int unsigned range_refusals = 0;
	int unsigned find_hits     = 0;
	int unsigned max_length    = 0;

	int  send_idle_pct = 0;
	int  rsp_idle_pct  = 0;
	int  no_gap_left   = 0;
	int  hold_request  = 0;
	int  stall_left    = 0;
	bit  quiet         = 1'b0;

	positional_list_engine #(
		.DEPTH(LIST_DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$error("timeout after %0d cycles, %0d results still pending",
			cycle_count, pending_results.size());
		$display("TEST FAILED");
		$finish;
	end

	// Applies one request to the shadow list and returns the result it should produce.
	function automatic ple_pkg::rsp_t apply_list_request(ple_pkg::req_t r);
		ple_pkg::rsp_t o;
		int unsigned   p;
		int unsigned   i;
		o = '0;
		p = 32'(r.position);
		case (r.mode)
		ple_pkg::MODE_INSERT: begin
			if (list_count >= LIST_DEPTH) begin
				o.status = ple_pkg::ST_FULL;
			end else if (p > list_count) begin
				o.status = ple_pkg::ST_RANGE;
			end else begin
				for (i = list_count; i > p; i--)
					list_mem[i] = list_mem[i - 1];
				list_mem[p] = r.item_value;
				list_count++;
			end
		end
		ple_pkg::MODE_REMOVE: begin
			if (list_count == 0) begin
				o.status = ple_pkg::ST_EMPTY;
			end else if (p >= list_count) begin
				o.status = ple_pkg::ST_RANGE;
			end else begin
				o.read_value = list_mem[p];
				for (i = p; i + 1 < list_count; i++)
					list_mem[i] = list_mem[i + 1];
				list_count--;
			end
		end
		ple_pkg::MODE_GET, ple_pkg::MODE_SET: begin
			if (list_count == 0) begin
				o.status = ple_pkg::ST_EMPTY;
			end else if (p >= list_count) begin
				o.status = ple_pkg::ST_RANGE;
			end else if (r.mode == ple_pkg::MODE_GET) begin
				o.read_value = list_mem[p];
			end else begin
				list_mem[p] = r.item_value;
			end
		end
		ple_pkg::MODE_FIND: begin
			for (i = 0; i < list_count && !o.found; i++) begin
				if (list_mem[i] == r.item_value) begin
					o.found          = 1'b1;
					o.found_position = ple_pkg::FPOS_W'(i);
				end
			end
		end
		ple_pkg::MODE_CLEAR: begin
			list_count = 0;
		end
		default: begin
		end
		endcase
		o.list_length = ple_pkg::LEN_W'(list_count);
		return o;
	endfunction

	function automatic ple_pkg::req_t next_random_request(episode_e ep);
		ple_pkg::req_t r;
		int            cut [6];
		int            roll;
		int unsigned   hi;
		case (ep)
		EP_GROW:   cut = '{60, 70, 80, 88, 97, 98};
		EP_SHRINK: cut = '{15, 60, 70, 78, 95, 97};
		EP_MIXED:  cut = '{30, 50, 65, 78, 94, 97};
		default:   cut = '{15, 25, 50, 65, 95, 97};
		endcase
		roll = $urandom_range(0, 99);
		if (roll < cut[0])      r.mode = ple_pkg::MODE_INSERT;
		else if (roll < cut[1]) r.mode = ple_pkg::MODE_REMOVE;
		else if (roll < cut[2]) r.mode = ple_pkg::MODE_GET;
		else if (roll < cut[3]) r.mode = ple_pkg::MODE_SET;
		else if (roll < cut[4]) r.mode = ple_pkg::MODE_FIND;
		else if (roll < cut[5]) r.mode = ple_pkg::MODE_CLEAR;
		else r.mode = $urandom_range(0, 1) ? MODE_UNUSED_HI : MODE_UNUSED_LO;

		// Mostly legal positions, with the list ends favored and some fully random.
		if (r.mode == ple_pkg::MODE_INSERT)
			hi = list_count;
		else
			hi = (list_count == 0) ? 0 : list_count - 1;
		roll = $urandom_range(0, 99);
		if (roll < 15)
			r.position = ple_pkg::POS_W'($urandom_range(0, 31));
		else if (roll < 30)
			r.position = $urandom_range(0, 1) ? ple_pkg::POS_W'(hi) : '0;
		else
			r.position = ple_pkg::POS_W'($urandom_range(0, hi));

		// Reusing stored values makes finds hit and duplicates appear.
		roll = $urandom_range(0, 99);
		if (list_count != 0 && roll < ((r.mode == ple_pkg::MODE_FIND) ? 60 : 20)) begin
			r.item_value = list_mem[$urandom_range(0, list_count - 1)];
		end else begin
			case ($urandom_range(0, 9))
			0:       r.item_value = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
			1:       r.item_value = $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
			2, 3:    r.item_value = ple_pkg::VAL_W'($urandom_range(0, 7));
			default: r.item_value = $urandom();
			endcase
		end
		return r;
	endfunction

	function automatic int compare_field(string name, logic [ple_pkg::VAL_W-1:0] want,
		logic [ple_pkg::VAL_W-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	task automatic check_result(ple_pkg::rsp_t got);
		ple_pkg::rsp_t want;
		if (pending_results.size() == 0) begin
			$error("result transfer with nothing pending: 0x%0h", got);
			errors++;
		end else begin
			want = pending_results.pop_front();
			results_seen++;
			errors += compare_field("read_value", want.read_value, got.read_value);
			errors += compare_field("found", ple_pkg::VAL_W'(want.found),
				ple_pkg::VAL_W'(got.found));
			errors += compare_field("found_position",
				ple_pkg::VAL_W'(want.found_position), ple_pkg::VAL_W'(got.found_position));
			errors += compare_field("list_length", ple_pkg::VAL_W'(want.list_length),
				ple_pkg::VAL_W'(got.list_length));
			errors += compare_field("status", ple_pkg::VAL_W'(want.status),
				ple_pkg::VAL_W'(got.status));
		end
	endtask

	// Result side: checks every transfer and stalls in random bursts or one long hold.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				check_result(rsp);
			if (hold_request != 0) begin
				stall_left   = hold_request;
				hold_request = 0;
			end else if (stall_left == 0 && !quiet && $urandom_range(0, 99) < rsp_idle_pct) begin
				stall_left = $urandom_range(1, 7);
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	task automatic send_request(ple_pkg::req_t r, bit typed, ple_pkg::rsp_t typed_rsp);
		ple_pkg::rsp_t predicted;
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		predicted = apply_list_request(r);
		pending_results.push_back(typed ? typed_rsp : predicted);
		requests_sent++;
		if (predicted.status == ple_pkg::ST_FULL)  full_refusals++;
		if (predicted.status == ple_pkg::ST_EMPTY) empty_refusals++;
		if (predicted.status == ple_pkg::ST_RANGE) range_refusals++;
		if (predicted.found)                       find_hits++;
		if (list_count > max_length)               max_length = list_count;
		if (no_gap_left > 0) begin
			no_gap_left--;
		end else if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic add_row(bit typed, logic [ple_pkg::MODE_W-1:0] mode, int pos,
		logic [ple_pkg::VAL_W-1:0] val, logic [ple_pkg::VAL_W-1:0] rd, bit fnd, int fpos,
		int len, logic [ple_pkg::ST_W-1:0] st);
		stim_row_t row;
		row.r.mode                = mode;
		row.r.position            = ple_pkg::POS_W'(pos);
		row.r.item_value          = val;
		row.typed                 = typed;
		row.want.read_value       = rd;
		row.want.found            = fnd;
		row.want.found_position   = ple_pkg::FPOS_W'(fpos);
		row.want.list_length      = ple_pkg::LEN_W'(len);
		row.want.status           = st;
		stim_rows.push_back(row);
	endtask

	initial begin
		episode_e ep;
		int       ep_left;
		int       n;

		// Requests on an empty list, then building a short list at its edges.
		add_row(1, ple_pkg::MODE_GET,    0,  0,       0,       0, 0, 0, ple_pkg::ST_EMPTY);
		add_row(1, ple_pkg::MODE_REMOVE, 0,  0,       0,       0, 0, 0, ple_pkg::ST_EMPTY);
		add_row(1, ple_pkg::MODE_SET,    0,  9,       0,       0, 0, 0, ple_pkg::ST_EMPTY);
		add_row(1, ple_pkg::MODE_FIND,   0,  0,       0,       0, 0, 0, ple_pkg::ST_OK);
		add_row(1, ple_pkg::MODE_INSERT, 1,  3,       0,       0, 0, 0, ple_pkg::ST_RANGE);
		add_row(1, ple_pkg::MODE_INSERT, 0,  VAL_MAX, 0,       0, 0, 1, ple_pkg::ST_OK);
		add_row(1, ple_pkg::MODE_REMOVE, 0,  0,       VAL_MAX, 0, 0, 0, ple_pkg::ST_OK);
		add_row(1, ple_pkg::MODE_INSERT, 0,  VAL_MIN, 0,       0, 0, 1, ple_pkg::ST_OK);
		add_row(1, ple_pkg::MODE_INSERT, 0,  -1,      0,       0, 0, 2, ple_pkg::ST_OK);
		add_row(1, ple_pkg::MODE_INSERT, 2,  0,       0,       0, 0, 3, ple_pkg::ST_OK);
		add_row(0, ple_pkg::MODE_INSERT, 1,  42,      0,       0, 0, 0, ple_pkg::ST_OK);
		add_row(0, ple_pkg::MODE_GET,    2,  0,       0,       0, 0, 0, ple_pkg::ST_OK);
		add_row(0, ple_pkg::MODE_FIND,   0,  0,       0,       0, 0, 0, ple_pkg::ST_OK);
		add_row(1, ple_pkg::MODE_FIND,   0,  -1,      0,       1, 0, 4, ple_pkg::ST_OK);
		add_row(1, ple_pkg::MODE_FIND,   0,  12345,   0,       0, 0, 4, ple_pkg::ST_OK);
		add_row(0, ple_pkg::MODE_SET,    3,  VAL_MAX, 0,       0, 0, 0, ple_pkg::ST_OK);
		add_row(1, ple_pkg::MODE_GET,    4,  0,       0,       0, 0, 4, ple_pkg::ST_RANGE);
		add_row(1, ple_pkg::MODE_REMOVE, 31, 0,       0,       0, 0, 4, ple_pkg::ST_RANGE);
		add_row(1, ple_pkg::MODE_INSERT, 31, 1,       0,       0, 0, 4, ple_pkg::ST_RANGE);
		add_row(1, MODE_UNUSED_LO,       0,  5,       0,       0, 0, 4, ple_pkg::ST_OK);
		add_row(1, MODE_UNUSED_HI,       31, -1,      0,       0, 0, 4, ple_pkg::ST_OK);
		add_row(0, ple_pkg::MODE_REMOVE, 1,  0,       0,       0, 0, 0, ple_pkg::ST_OK);
		add_row(1, ple_pkg::MODE_CLEAR,  0,  0,       0,       0, 0, 0, ple_pkg::ST_OK);
		add_row(1, ple_pkg::MODE_GET,    0,  0,       0,       0, 0, 0, ple_pkg::ST_EMPTY);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 20;
		rsp_idle_pct  = 20;
		foreach (stim_rows[k])
			send_request(stim_rows[k].r, stim_rows[k].typed, stim_rows[k].want);

		// The first episode grows the list so that full-list refusals show up early.
		ep      = EP_GROW;
		ep_left = 80;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (ep_left == 0) begin
				ep            = episode_e'($urandom_range(0, 3));
				ep_left       = $urandom_range(20, 80);
				send_idle_pct = 15 * $urandom_range(0, 3);
				rsp_idle_pct  = 15 * $urandom_range(0, 3);
			end
			ep_left--;
			if (n == LONG_HOLD_AT) begin
				// The result side holds off while requests keep coming back to back,
				// so the block has to stall its request side.
				hold_request = LONG_HOLD_LEN;
				no_gap_left  = 60;
			end
			if (n == DRAIN_AT) begin
				req_valid <= 1'b0;
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			if (n == RANDOM_ITEMS - QUIET_ITEMS)
				quiet = 1'b1;
			send_request(next_random_request(ep), 1'b0, '0);
		end

		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d requests, %0d results checked in %0d cycles; longest list %0d",
			requests_sent, results_seen, cycle_count, max_length);
		$display("refusals: %0d full, %0d empty, %0d out of range; %0d finds hit",
			full_refusals, empty_refusals, range_refusals, find_hits);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: positional_list_engine.f
hw/rtl/ple_pkg.sv
hw/rtl/ple_ram.sv
hw/rtl/positional_list_engine.sv
tb/testbench.sv
